// File: rtl/compacting_item_count_table_core_macros.svh
// Assertion macros for the compacting item count table checker.
// Expects signals named clock and reset in the scope of use.
`ifndef COMPACTING_ITEM_COUNT_TABLE_CORE_MACROS_SVH
`define COMPACTING_ITEM_COUNT_TABLE_CORE_MACROS_SVH

// Checked outside reset.
`define CITC_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("citc check failed");

// Checked on every edge, reset included.
`define CITC_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("citc check failed");

`endif

// File: rtl/citc_pkg.sv
// Shared types and constants for the compacting item count table.
// No dependencies.
package citc_pkg;

   localparam int unsigned ENTRIES_DEFAULT = 64;
   localparam int unsigned ID_W            = 16;
   localparam int unsigned CNT_W           = 16;

   localparam logic [CNT_W-1:0] COUNT_MAX = '1;

   localparam logic [1:0] CMD_PLACE  = 2'd0;
   localparam logic [1:0] CMD_PICKUP = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   typedef struct packed {
      logic [1:0]       command;
      logic [ID_W-1:0]  item_id;
      logic [CNT_W-1:0] amount;
   } req_type;

   typedef struct packed {
      logic             ok;
      logic [CNT_W-1:0] count;
      logic             table_full;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]  item_id;
      logic [CNT_W-1:0] count;
   } entry_type;

endpackage

// File: rtl/citc_entry_ram.sv
// Entry store: one write port, one read port, registered read data.
// Depends on citc_pkg for the entry type.
module citc_entry_ram #(
   parameter int unsigned DEPTH = citc_pkg::ENTRIES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  citc_pkg::entry_type        wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output citc_pkg::entry_type        rd_data
);
   import citc_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/compacting_item_count_table_core.sv
// Compacting item count table core.
// Handles one request at a time: a linear scan for the id, then an update, and on a pickup
// that empties and removes its entry, a shift that moves each later entry up one slot.
// The next request is taken in the same cycle the response shows, once any stalled earlier
// response has been taken; the pace is set by the linear scan and the single RAM read port.
// Reset clears fill count and control; RAM is not swept.
module compacting_item_count_table_core #(
   parameter int unsigned ENTRIES = citc_pkg::ENTRIES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  citc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output citc_pkg::rsp_type rsp_data
);
   import citc_pkg::*;

   // Slot index and fill count widths; the fill count must hold ENTRIES itself.
   localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned USE_W = $clog2(ENTRIES + 1);
   localparam int unsigned CMP_W = USE_W + 1;
   localparam logic [USE_W-1:0] FULL_FILL = USE_W'(ENTRIES);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_UPDATE,
      S_SHIFT,
      S_RESP
   } state_type;

   state_type        state_ff, state_in;
   logic [1:0]       cmd_ff, cmd_in;
   logic [ID_W-1:0]  id_ff, id_in;
   logic [CNT_W-1:0] amt_ff, amt_in;
   logic [USE_W-1:0] used_ff, used_in;     // entries live in slots 0 .. used-1
   logic [USE_W-1:0] scan_ff, scan_in;     // next slot to read
   logic             rd_vld_ff, rd_vld_in; // RAM output holds slot hit_ff
   logic [IDX_W-1:0] hit_ff, hit_in;
   logic [CNT_W-1:0] cur_ff, cur_in;       // count of the matching entry
   logic             found_ff, found_in;
   logic [IDX_W-1:0] mv_ff, mv_in;         // compaction write slot
   rsp_type          res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   entry_type        ram_wr_data;
   logic             ram_rd_en;
   logic [IDX_W-1:0] ram_rd_addr;
   entry_type        ram_rd_data;

   citc_entry_ram #(
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // All RAM accesses come from this one sequencer, one request at a time, so a
   // read never meets a write to the same slot in the same cycle: the FSM is the
   // interlock. During compaction slot j is written while slot j+2 is read.
   always_comb begin
      logic [CNT_W:0]   sum_wide;
      logic [CNT_W-1:0] diff;
      logic             match;

      state_in     = state_ff;
      cmd_in       = cmd_ff;
      id_in        = id_ff;
      amt_in       = amt_ff;
      used_in      = used_ff;
      scan_in      = scan_ff;
      rd_vld_in    = rd_vld_ff;
      hit_in       = hit_ff;
      cur_in       = cur_ff;
      found_in     = found_ff;
      mv_in        = mv_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      ram_wr_en    = 1'b0;
      ram_wr_addr  = hit_ff;
      ram_wr_data  = '{item_id: id_ff, count: cur_ff};
      ram_rd_en    = 1'b0;
      ram_rd_addr  = scan_ff[IDX_W-1:0];

      sum_wide = {1'b0, cur_ff} + {1'b0, amt_ff};
      diff     = cur_ff - amt_ff;
      match    = rd_vld_ff && (ram_rd_data.item_id == id_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_data.command;
               id_in     = req_data.item_id;
               amt_in    = req_data.amount;
               scan_in   = '0;
               rd_vld_in = 1'b0;
               found_in  = 1'b0;
               res_in    = '0;
               if (req_data.item_id == '0 ||
                   (req_data.command != CMD_PLACE && req_data.command != CMD_PICKUP &&
                    req_data.command != CMD_QUERY)) begin
                  state_in = S_RESP;  // ignored: zero id or unused command code
               end else begin
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            if (match) begin
               found_in = 1'b1;
               cur_in   = ram_rd_data.count;
               state_in = S_UPDATE;
            end else if (scan_ff < used_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = scan_ff[IDX_W-1:0];
               hit_in      = scan_ff[IDX_W-1:0];
               rd_vld_in   = 1'b1;
               scan_in     = scan_ff + 1'b1;
            end else begin
               found_in = 1'b0;
               state_in = S_UPDATE;
            end
         end

         S_UPDATE: begin
            state_in = S_RESP;
            res_in   = '0;
            case (cmd_ff)
               CMD_PLACE: begin
                  if (found_ff) begin
                     ram_wr_en = 1'b1;
                     ram_wr_addr = hit_ff;
                     ram_wr_data.count = sum_wide[CNT_W] ? COUNT_MAX : sum_wide[CNT_W-1:0];
                     res_in.ok    = 1'b1;
                     res_in.count = ram_wr_data.count;
                  end else if (used_ff < FULL_FILL) begin
                     // append in the first empty slot
                     ram_wr_en         = 1'b1;
                     ram_wr_addr       = used_ff[IDX_W-1:0];
                     ram_wr_data.count = amt_ff;
                     used_in           = used_ff + 1'b1;
                     res_in.ok         = 1'b1;
                     res_in.count      = amt_ff;
                  end else begin
                     res_in.table_full = 1'b1;
                  end
               end
               CMD_PICKUP: begin
                  if (found_ff && amt_ff > cur_ff) begin
                     res_in.count = cur_ff;  // too few: report, leave alone
                  end else if (found_ff) begin
                     res_in.ok    = 1'b1;
                     res_in.count = diff;
                     if (diff != '0) begin
                        ram_wr_en         = 1'b1;
                        ram_wr_addr       = hit_ff;
                        ram_wr_data.count = diff;
                     end else if (CMP_W'(hit_ff) + 1'b1 < CMP_W'(used_ff)) begin
                        // emptied with entries behind it: start the shift
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = IDX_W'(CMP_W'(hit_ff) + 1'b1);
                        mv_in       = hit_ff;
                        state_in    = S_SHIFT;
                     end else begin
                        used_in = used_ff - 1'b1;  // emptied last entry
                     end
                  end
               end
               CMD_QUERY: begin
                  res_in.ok    = found_ff;
                  res_in.count = found_ff ? cur_ff : '0;
               end
               default: begin
                  res_in = '0;
               end
            endcase
         end

         S_SHIFT: begin
            // RAM output holds slot mv+1; move it up one slot
            ram_wr_en   = 1'b1;
            ram_wr_addr = mv_ff;
            ram_wr_data = ram_rd_data;
            if (CMP_W'(mv_ff) + 2'd2 < CMP_W'(used_ff)) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = IDX_W'(CMP_W'(mv_ff) + 2'd2);
               mv_in       = mv_ff + 1'b1;
            end else begin
               used_in  = used_ff - 1'b1;
               state_in = S_RESP;
            end
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      id_ff       <= id_in;
      amt_ff      <= amt_in;
      scan_ff     <= scan_in;
      hit_ff      <= hit_in;
      cur_ff      <= cur_in;
      found_ff    <= found_in;
      mv_ff       <= mv_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: rtl/citc_checker.sv
// Port-level checks for the compacting item count table core, bound to the top.
// Depends on citc_pkg and the assertion macro header.
`include "compacting_item_count_table_core_macros.svh"

module citc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input citc_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input citc_pkg::rsp_type rsp_data
);
   import citc_pkg::*;

   logic req_fire;
   req_type req_seen;

   assign req_fire = req_valid && req_ready;
   assign req_seen = req_data;

   // one request in flight: taking a request closes the input in the next cycle
   `CITC_ASSERT(a_busy_after_req, req_fire |=> !req_ready)
   // a dropped place reports nothing else
   `CITC_ASSERT(a_full_clean, rsp_valid && rsp_data.table_full |-> !rsp_data.ok && rsp_data.count == '0)
   // a stalled response holds
   `CITC_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
   // reset leaves an empty output and an open input
   `CITC_ASSERT_ALWAYS(a_reset_state, reset |=> !rsp_valid && req_ready)

   // a request with a zero id never succeeds
   `CITC_ASSERT(a_zero_id, req_fire && req_seen.item_id == '0 |=> !rsp_valid || !rsp_data.ok || $past(rsp_valid))

endmodule

bind compacting_item_count_table_core citc_checker u_citc_checker (.*);

// File: bench/tb_compacting_item_count_table_core.sv
// Self-checking bench for compacting_item_count_table_core: random and directed requests,
// a built-in table predictor and an in-order response check.
// Depends on citc_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_compacting_item_count_table_core;
   import citc_pkg::*;

   localparam int unsigned ENTRIES      = ENTRIES_DEFAULT;
   localparam logic [1:0]  CMD_UNUSED   = 2'd3;   // no operation, block must ignore it
   localparam int          GEN_MIRROR   = 0;      // table copy used while building stimulus
   localparam int          CHECK_MIRROR = 1;      // table copy advanced on accepted requests
   localparam int          ID_POOL_SIZE = 96;     // a bit more ids than slots, so tables fill
   localparam int          RANDOM_REQS  = 950;
   localparam int          TAIL_CYCLES  = 200;    // longer than a full scan plus shift
   localparam int          REPORT_CAP   = 100;

   typedef struct packed {
      logic    hold;   // sender waits for all responses before this request
      req_type req;
   } queued_req_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Two copies of the table: one advanced as stimulus is built, one as the DUT accepts.
   logic [ID_W-1:0]  slot_ids    [2][ENTRIES] = '{default: '0};
   logic [CNT_W-1:0] slot_counts [2][ENTRIES] = '{default: '0};
   int unsigned      slots_used  [2]          = '{0, 0};

   queued_req_type pending_reqs[$];
   rsp_type        expected_rsps[$];

   int total_reqs     = 0;
   int accepted_count = 0;   // written with nonblocking updates only
   int checked_count  = 0;   // written with nonblocking updates only
   int error_count    = 0;
   int send_gap       = 0;
   int recv_gap       = 0;

   // stimulus statistics
   int cmd_seen[4]   = '{0, 0, 0, 0};
   int ignored_reqs  = 0;
   int full_drops    = 0;
   int removals      = 0;
   int ceiling_hits  = 0;

   logic no_idle;

   always #5 clock = ~clock;

   compacting_item_count_table_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Idling switched off in the last stretch of the run and in one window of every four.
   assign no_idle = (total_reqs - accepted_count) < 150 || ((accepted_count / 100) % 4 == 1);

   // ------------------------------------------------------------------
   // Table predictor
   // ------------------------------------------------------------------

   // Slot holding id in table copy m, or -1 when the id is not stored.
   function automatic int find_slot(input int m, input logic [ID_W-1:0] id);
      for (int i = 0; i < int'(slots_used[m]); i++)
         if (slot_ids[m][i] == id) return i;
      return -1;
   endfunction

   // Applies one request to table copy m and returns the response it must produce.
   function automatic rsp_type apply_command(input int m, input req_type r);
      rsp_type          res;
      int               k;
      logic [CNT_W:0]   sum;
      logic [CNT_W-1:0] left;
      res = '0;
      // zero id and the unused command code leave the table alone
      if (r.item_id == '0 || !(r.command inside {CMD_PLACE, CMD_PICKUP, CMD_QUERY}))
         return res;
      k = find_slot(m, r.item_id);
      case (r.command)
         CMD_PLACE: begin
            if (k >= 0) begin
               sum = {1'b0, slot_counts[m][k]} + {1'b0, r.amount};
               if (sum[CNT_W]) sum = {1'b0, COUNT_MAX};   // saturate
               slot_counts[m][k] = sum[CNT_W-1:0];
               res.ok    = 1'b1;
               res.count = sum[CNT_W-1:0];
            end else if (slots_used[m] < ENTRIES) begin
               // new entries append at the end, a zero amount still makes an entry
               slot_ids[m][slots_used[m]]    = r.item_id;
               slot_counts[m][slots_used[m]] = r.amount;
               slots_used[m]++;
               res.ok    = 1'b1;
               res.count = r.amount;
            end else begin
               res.table_full = 1'b1;
            end
         end
         CMD_PICKUP: begin
            if (k >= 0) begin
               if (r.amount > slot_counts[m][k]) begin
                  res.count = slot_counts[m][k];   // refused, report what is there
               end else begin
                  left = slot_counts[m][k] - r.amount;
                  slot_counts[m][k] = left;
                  if (left == '0) begin
                     // close the hole, later entries move up in order
                     for (int i = k; i + 1 < int'(slots_used[m]); i++) begin
                        slot_ids[m][i]    = slot_ids[m][i+1];
                        slot_counts[m][i] = slot_counts[m][i+1];
                     end
                     slots_used[m]--;
                     slot_ids[m][slots_used[m]]    = '0;
                     slot_counts[m][slots_used[m]] = '0;
                  end
                  res.ok    = 1'b1;
                  res.count = left;
               end
            end
         end
         default: begin
            if (k >= 0) begin
               res.ok    = 1'b1;
               res.count = slot_counts[m][k];
            end
         end
      endcase
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus building
   // ------------------------------------------------------------------

   task automatic queue_request(input logic [1:0] cmd, input logic [ID_W-1:0] id,
                                input logic [CNT_W-1:0] amt, input logic hold);
      queued_req_type q;
      rsp_type        r;
      q.hold          = hold;
      q.req.command   = cmd;
      q.req.item_id   = id;
      q.req.amount    = amt;
      r = apply_command(GEN_MIRROR, q.req);
      cmd_seen[cmd]++;
      if (id == '0 || cmd == CMD_UNUSED) ignored_reqs++;
      if (r.table_full) full_drops++;
      if (cmd == CMD_PICKUP && r.ok && r.count == '0) removals++;
      if (cmd == CMD_PLACE && r.ok && r.count == COUNT_MAX) ceiling_hits++;
      pending_reqs.push_back(q);
   endtask

   function automatic logic [CNT_W-1:0] stored_count(input logic [ID_W-1:0] id);
      int k;
      k = find_slot(GEN_MIRROR, id);
      return (k >= 0) ? slot_counts[GEN_MIRROR][k] : '0;
   endfunction

   function automatic logic [ID_W-1:0] any_stored_id();
      return slot_ids[GEN_MIRROR][$urandom_range(0, slots_used[GEN_MIRROR] - 1)];
   endfunction

   // ------------------------------------------------------------------
   // Request driver: one item from pending_reqs at a time, random gaps
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      queued_req_type head;
      logic           launch;
      launch = 1'b0;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            // request taken at this edge: predict its response now
            head = pending_reqs.pop_front();
            expected_rsps.push_back(apply_command(CHECK_MIRROR, head.req));
            accepted_count <= accepted_count + 1;
         end
         if (send_gap > 0)
            send_gap <= send_gap - 1;
         else if (!no_idle && $urandom_range(0, 9) == 0)
            send_gap <= $urandom_range(0, 15);   // start a random idle gap
         else if (pending_reqs.size() != 0)
            // a held request waits until nothing is outstanding
            launch = !(pending_reqs[0].hold &&
                       (req_valid || accepted_count != checked_count));
         req_valid <= launch;
         if (launch) req_data <= pending_reqs[0].req;
      end
   end

   // ------------------------------------------------------------------
   // Response monitor: in-order compare against expected_rsps
   // ------------------------------------------------------------------

   task automatic report_field(input string name, input int want, input int got);
      error_count++;
      if (error_count <= REPORT_CAP)
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap  <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            checked_count <= checked_count + 1;
            if (expected_rsps.size() == 0) begin
               error_count++;
               $error("response with no request outstanding: ok=%0d count=%0d table_full=%0d",
                      rsp_data.ok, rsp_data.count, rsp_data.table_full);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.ok !== want.ok)
                  report_field("ok", want.ok, rsp_data.ok);
               if (rsp_data.count !== want.count)
                  report_field("count", want.count, rsp_data.count);
               if (rsp_data.table_full !== want.table_full)
                  report_field("table_full", want.table_full, rsp_data.table_full);
            end
         end
         if (recv_gap > 0) begin
            recv_gap  <= recv_gap - 1;
            rsp_ready <= 1'b0;
         end else if (!no_idle && $urandom_range(0, 9) == 0) begin
            recv_gap  <= $urandom_range(0, 15);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------

   initial begin
      logic [ID_W-1:0]  id_pool[ID_POOL_SIZE];
      logic [ID_W-1:0]  id;
      logic [CNT_W-1:0] amt;
      logic [CNT_W-1:0] have;
      logic [1:0]       cmd;
      int               random_reqs;
      int               sel;
      int               n;

      id_pool[0] = 16'h0001;
      id_pool[1] = 16'hFFFF;
      for (int i = 2; i < ID_POOL_SIZE; i++) id_pool[i] = $urandom_range(1, 65535);

      // Directed: absent item, zero-count entry, saturation, refused pickup,
      // removals at the head and in the middle, zero id and the unused command.
      queue_request(CMD_QUERY,  16'h0001, 16'h0000, 1'b0);
      queue_request(CMD_PICKUP, 16'h0001, 16'h0005, 1'b0);
      queue_request(CMD_PLACE,  16'h0001, 16'h0000, 1'b0);
      queue_request(CMD_QUERY,  16'h0001, 16'h0000, 1'b0);
      queue_request(CMD_PLACE,  16'h0001, 16'hFFFF, 1'b0);
      queue_request(CMD_PLACE,  16'h0001, 16'h0005, 1'b0);
      queue_request(CMD_PLACE,  16'hFFFF, 16'hFFFF, 1'b0);
      queue_request(CMD_PLACE,  16'h8000, 16'd1234, 1'b0);
      queue_request(CMD_PLACE,  16'h5555, 16'hAAAA, 1'b0);
      queue_request(CMD_PLACE,  16'hAAAA, 16'h5555, 1'b0);
      queue_request(CMD_PICKUP, 16'h8000, 16'd2000, 1'b0);
      queue_request(CMD_PICKUP, 16'h0001, 16'hFFFF, 1'b0);
      queue_request(CMD_QUERY,  16'hFFFF, 16'h0000, 1'b0);
      queue_request(CMD_PICKUP, 16'h8000, 16'd1234, 1'b0);
      queue_request(CMD_PLACE,  16'h0007, 16'h0000, 1'b0);
      queue_request(CMD_PICKUP, 16'h0007, 16'h0000, 1'b0);
      queue_request(CMD_PLACE,  16'h0000, 16'h0005, 1'b0);
      queue_request(CMD_PICKUP, 16'h0000, 16'h0005, 1'b0);
      queue_request(CMD_QUERY,  16'h0000, 16'h0000, 1'b0);
      queue_request(CMD_UNUSED, 16'h5555, 16'h0007, 1'b0);
      queue_request(CMD_PICKUP, 16'h5555, 16'h0001, 1'b0);
      queue_request(CMD_QUERY,  16'hAAAA, 16'h0000, 1'b0);

      // Random part, built from short sequences. Ignored requests do not count.
      random_reqs = 0;
      while (random_reqs < RANDOM_REQS) begin
         case ($urandom_range(0, 9))
            0: begin
               // fill to the brim with fresh ids, then knock on the full table
               n = 0;
               while (slots_used[GEN_MIRROR] < ENTRIES) begin
                  do id = $urandom_range(1, 65535); while (find_slot(GEN_MIRROR, id) >= 0);
                  queue_request(CMD_PLACE, id, $urandom_range(1, 300), n == 0);
                  n++;
               end
               repeat ($urandom_range(1, 3)) begin
                  do id = $urandom_range(1, 65535); while (find_slot(GEN_MIRROR, id) >= 0);
                  queue_request(CMD_PLACE, id, $urandom, n == 0);
                  n++;
               end
               queue_request(CMD_PLACE, any_stored_id(), $urandom_range(0, 50), 1'b0);
               random_reqs += n + 1;
            end
            1, 2: begin
               // drain: exact pickups at random positions force shifts everywhere
               if (slots_used[GEN_MIRROR] != 0) begin
                  n = $urandom_range(1, slots_used[GEN_MIRROR]);
                  repeat (n) begin
                     id = any_stored_id();
                     queue_request(CMD_PICKUP, id, stored_count(id), 1'b0);
                  end
                  random_reqs += n;
               end
            end
            default: begin
               repeat (20) begin
                  sel = $urandom_range(0, 99);
                  if (sel < 4) begin
                     // noise: zero id with any command, or the unused code
                     if ($urandom_range(0, 1))
                        queue_request($urandom_range(0, 3), 16'h0000, $urandom, 1'b0);
                     else
                        queue_request(CMD_UNUSED, $urandom_range(1, 65535), $urandom, 1'b0);
                  end else begin
                     cmd = (sel < 45) ? CMD_PLACE : (sel < 80) ? CMD_PICKUP : CMD_QUERY;
                     if (slots_used[GEN_MIRROR] != 0 && $urandom_range(0, 9) < 7)
                        id = any_stored_id();
                     else
                        id = id_pool[$urandom_range(0, ID_POOL_SIZE - 1)];
                     have = stored_count(id);
                     if (cmd == CMD_PLACE) begin
                        case ($urandom_range(0, 9))
                           0:       amt = '0;
                           1:       amt = COUNT_MAX;
                           2:       amt = $urandom;
                           default: amt = $urandom_range(1, 200);
                        endcase
                     end else if (cmd == CMD_PICKUP) begin
                        case ($urandom_range(0, 5))
                           0, 1:    amt = have;
                           2:       amt = $urandom_range(0, have);
                           3:       amt = (have == COUNT_MAX) ? have : have + 1'b1;
                           4:       amt = $urandom;
                           default: amt = $urandom_range(0, 3);
                        endcase
                     end else begin
                        amt = $urandom;
                     end
                     queue_request(cmd, id, amt, 1'b0);
                     random_reqs++;
                  end
               end
            end
         endcase
      end
      // the sender drains the block once more near the end
      pending_reqs[pending_reqs.size() - 200].hold = 1'b1;
      total_reqs = pending_reqs.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (checked_count < total_reqs) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_rsps.size() != 0) begin
         error_count++;
         $error("%0d expected responses never arrived", expected_rsps.size());
      end

      $display("tb: %0d requests sent: %0d place, %0d pickup, %0d query, %0d ignored",
               total_reqs, cmd_seen[CMD_PLACE], cmd_seen[CMD_PICKUP], cmd_seen[CMD_QUERY],
               ignored_reqs);
      $display("tb: %0d places dropped on a full table, %0d entries removed, %0d at ceiling",
               full_drops, removals, ceiling_hits);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Watchdog, several times the slowest legal run.
   initial begin
      #8_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/citc_pkg.sv
rtl/citc_entry_ram.sv
rtl/compacting_item_count_table_core.sv
rtl/citc_checker.sv
bench/tb_compacting_item_count_table_core.sv
